/* rtl/sckd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sckd_pkg
// Shared types and constants for the sha1 counter-mode keystream decryptor.
// ----------------------------------------------------------------------------
package sckd_pkg;

  localparam int unsigned ROUNDS  = 80;
  localparam int unsigned RND_W   = 7;
  localparam int unsigned MSG_WDS = 16;

  // configuration register indexes
  localparam logic REG_SEED_A = 1'b0;
  localparam logic REG_SEED_B = 1'b1;

  // sha-1 initial hash value
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hc3d2e1f0;

  // round constants
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // padding block for one 512-bit message
  localparam logic [31:0] PAD_FIRST = 32'h80000000;
  localparam logic [31:0] PAD_LEN   = 32'h00000200;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND1,
    S_FOLD1,
    S_ROUND2,
    S_FOLD2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic init;
    logic round;
    logic fold1;
    logic fold2;
    logic emit_direct;
    logic emit_hold;
  } cmd_t;

  typedef struct packed {
    logic ks_valid;
    logic out_free;
    logic rnd_last;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/sckd_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sckd_ctrl
// Sequencer: request intake, two-block sha-1 run and result hand-off.
// ----------------------------------------------------------------------------
module sckd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire sckd_pkg::sts_t sts,
  output sckd_pkg::cmd_t     cmd,
  output sckd_pkg::state_t   state
);
  import sckd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (!sts.ks_valid) begin
            cmd.init  = 1'b1;
            state_nxt = S_ROUND1;
          end else if (sts.out_free) begin
            cmd.emit_direct = 1'b1;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_ROUND1: begin
        cmd.round = 1'b1;
        if (sts.rnd_last) begin
          state_nxt = S_FOLD1;
        end
      end
      S_FOLD1: begin
        cmd.fold1 = 1'b1;
        state_nxt = S_ROUND2;
      end
      S_ROUND2: begin
        cmd.round = 1'b1;
        if (sts.rnd_last) begin
          state_nxt = S_FOLD2;
        end
      end
      S_FOLD2: begin
        cmd.fold2 = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_hold = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule
`default_nettype wire

/* rtl/sckd_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sckd_datapath
// Seeds, block counter, sha-1 round engine, keystream and output register.
// ----------------------------------------------------------------------------
module sckd_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire sckd_pkg::in_item_t in_data,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output sckd_pkg::out_item_t     out_data,
  input  wire sckd_pkg::cmd_t     cmd,
  output sckd_pkg::sts_t          sts
);
  import sckd_pkg::*;

  logic [63:0]      seed_a_r, seed_b_r;
  logic [63:0]      ctr_r;
  logic [3:0]       pos_r;
  logic [127:0]     ks_r;
  logic             ksv_r;
  in_item_t         hold_r;
  logic             out_valid_r;
  out_item_t        out_data_r;
  logic [RND_W-1:0] rnd_r;
  logic [31:0]      a_r, b_r, c_r, d_r, e_r;
  logic [31:0]      h_r [0:4];
  logic [31:0]      win_r [0:MSG_WDS-1];

  logic [31:0]      f_val, k_val, tmp_val, w_new;
  logic [31:0]      sum [0:4];
  logic             out_free;
  logic             emit;
  in_item_t         src;
  logic [7:0]       ks_byte;

  // round function and constant by round group
  always_comb begin
    if (rnd_r < RND_W'(20)) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K0;
    end else if (rnd_r < RND_W'(40)) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K1;
    end else if (rnd_r < RND_W'(60)) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K3;
    end
  end

  assign tmp_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + win_r[0];

  logic [31:0] w_mix;
  assign w_mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  assign sum[0] = h_r[0] + a_r;
  assign sum[1] = h_r[1] + b_r;
  assign sum[2] = h_r[2] + c_r;
  assign sum[3] = h_r[3] + d_r;
  assign sum[4] = h_r[4] + e_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_a_r <= '0;
      seed_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED_A: seed_a_r <= cfg_data;
        REG_SEED_B: seed_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // round engine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (cmd.init || cmd.fold1) begin
      rnd_r <= '0;
    end else if (cmd.round) begin
      rnd_r <= rnd_r + RND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      a_r <= IV0; b_r <= IV1; c_r <= IV2; d_r <= IV3; e_r <= IV4;
      h_r[0] <= IV0; h_r[1] <= IV1; h_r[2] <= IV2; h_r[3] <= IV3; h_r[4] <= IV4;
      win_r[0]  <= seed_a_r[63:32];
      win_r[1]  <= seed_a_r[31:0];
      win_r[2]  <= seed_a_r[63:32];
      win_r[3]  <= seed_a_r[31:0];
      win_r[4]  <= seed_b_r[63:32];
      win_r[5]  <= seed_b_r[31:0];
      win_r[6]  <= seed_b_r[63:32];
      win_r[7]  <= seed_b_r[31:0];
      for (int i = 8; i < 14; i++) begin
        win_r[i] <= '0;
      end
      win_r[14] <= ctr_r[63:32];
      win_r[15] <= ctr_r[31:0];
    end else if (cmd.round) begin
      a_r <= tmp_val;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
      for (int i = 0; i < MSG_WDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[MSG_WDS-1] <= w_new;
    end else if (cmd.fold1) begin
      a_r <= sum[0]; b_r <= sum[1]; c_r <= sum[2]; d_r <= sum[3]; e_r <= sum[4];
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= sum[i];
      end
      win_r[0] <= PAD_FIRST;
      for (int i = 1; i < MSG_WDS - 1; i++) begin
        win_r[i] <= '0;
      end
      win_r[MSG_WDS-1] <= PAD_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fold2) begin
      ks_r <= {sum[0], sum[1], sum[2], sum[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hold_r <= in_data;
    end
  end

  // decrypt and stream position
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd.emit_direct || cmd.emit_hold;
  assign src      = cmd.emit_direct ? in_data : hold_r;
  assign ks_byte  = ks_r[{~pos_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r       <= '0;
      pos_r       <= '0;
      ksv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fold2) begin
        ksv_r <= 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        if (src.last_byte) begin
          ctr_r <= '0;
          pos_r <= '0;
          ksv_r <= 1'b0;
        end else if (pos_r == 4'hf) begin
          ctr_r <= ctr_r + 64'd1;
          pos_r <= '0;
          ksv_r <= 1'b0;
        end else begin
          pos_r <= pos_r + 4'd1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.plain_byte <= src.cipher_byte ^ ks_byte;
      out_data_r.last_out   <= src.last_byte;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.ks_valid = ksv_r;
  assign sts.out_free = out_free;
  assign sts.rnd_last = (rnd_r == RND_W'(ROUNDS - 1));

endmodule
`default_nettype wire

/* rtl/sha1_counter_keystream_decryptor_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_counter_keystream_decryptor_top
// Stream decryptor: bytes xor a keystream of sha-1 digests over seeds and
// a 64-bit block counter, restarted after each byte flagged last.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | in_data   (cipher_byte, last_byte)
//  out      | out_valid/out_stall| out_data  (plain_byte, last_out)
//  cfg      | cfg_valid/cfg_ready| cfg_index (0 seed_a, 1 seed_b), cfg_data
//
//  bytes 1..15 of a block: one request per cycle while the output register drains
//  first byte of a block: hashed by the one-round-per-cycle sha-1
//  engine running 80 rounds on each of two blocks plus fold and emit steps
//  reset clears position, counter, keystream valid, seeds and output valid
//  in_stall is high while a request is hashed or waits for the output register
// ----------------------------------------------------------------------------
module sha1_counter_keystream_decryptor_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire sckd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output sckd_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [63:0]         cfg_data
);
  import sckd_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  assign cfg_ready = 1'b1;

  sckd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  sckd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  a_no_ks_while_hashing: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_ROUND1 || state == S_ROUND2 || state == S_FOLD1) |-> !sts.ks_valid)
    else $error("keystream marked valid during hashing");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_hold || cmd.emit_direct) |-> sts.out_free)
    else $error("result written over a pending output");

  a_fold_after_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fold1 || cmd.fold2) |-> $past(sts.rnd_last))
    else $error("fold without completed round sequence");

  a_ks_after_fold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fold2 |=> sts.ks_valid)
    else $error("keystream not valid after final fold");

endmodule
`default_nettype wire
